/* design/irpd_pkg.sv */
`default_nettype none

package irpd_pkg;

    // Fixed field widths
    localparam int ChanBits  = 3;
    localparam int TimeBits  = 32;
    localparam int CmdBits   = 24;
    localparam int WinBits   = 8;
    localparam int RegIdxBits = 3;
    localparam int BitIdxBits = (CmdBits > 1) ? $clog2(CmdBits) : 1;

    // Configuration register indexes
    localparam logic [RegIdxBits-1:0] REG_CAPTION_MIN = 3'd0;
    localparam logic [RegIdxBits-1:0] REG_CAPTION_MAX = 3'd1;
    localparam logic [RegIdxBits-1:0] REG_ONE_MIN     = 3'd2;
    localparam logic [RegIdxBits-1:0] REG_ONE_MAX     = 3'd3;
    localparam logic [RegIdxBits-1:0] REG_ZERO_MIN    = 3'd4;
    localparam logic [RegIdxBits-1:0] REG_ZERO_MAX    = 3'd5;

    // Register reset values
    localparam logic [WinBits-1:0] CAPTION_MIN_RST = 8'd20;
    localparam logic [WinBits-1:0] CAPTION_MAX_RST = 8'd26;
    localparam logic [WinBits-1:0] ONE_MIN_RST     = 8'd10;
    localparam logic [WinBits-1:0] ONE_MAX_RST     = 8'd14;
    localparam logic [WinBits-1:0] ZERO_MIN_RST    = 8'd4;
    localparam logic [WinBits-1:0] ZERO_MAX_RST    = 8'd8;

    typedef struct packed {
        logic [ChanBits-1:0] channel;
        logic                pin_high;
        logic [TimeBits-1:0] timestamp;
    } evt_t;

    typedef struct packed {
        logic [ChanBits-1:0] out_channel;
        logic [CmdBits-1:0]  command;
        logic                new_command;
    } res_t;

    typedef struct packed {
        logic [WinBits-1:0] caption_min;
        logic [WinBits-1:0] caption_max;
        logic [WinBits-1:0] one_min;
        logic [WinBits-1:0] one_max;
        logic [WinBits-1:0] zero_min;
        logic [WinBits-1:0] zero_max;
    } win_cfg_t;

    // Per-channel state; done marks that all bits are in (the bit at index zero was taken)
    typedef struct packed {
        logic [TimeBits-1:0]   last_time;
        logic [CmdBits-1:0]    shift_data;
        logic                  done;
        logic [BitIdxBits-1:0] bit_idx;
        logic [CmdBits-1:0]    latched;
    } chan_state_t;

    localparam chan_state_t STATE_RST = '{
        last_time:  '0,
        shift_data: '0,
        done:       1'b0,
        bit_idx:    BitIdxBits'(CmdBits - 1),
        latched:    '0
    };

endpackage

`default_nettype wire

/* design/irpd_ram.sv */
`default_nettype none

module irpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/irpd_update.sv */
`default_nettype none

module irpd_update (
    input  wire irpd_pkg::win_cfg_t                  cfg,
    input  wire irpd_pkg::chan_state_t               cur,
    input  wire logic                                pin_high,
    input  wire logic [irpd_pkg::TimeBits-1:0]       timestamp,
    output irpd_pkg::chan_state_t                    nxt,
    output logic                                     fresh
);

    logic [irpd_pkg::TimeBits-1:0] dt;
    logic                          hit_caption;
    logic                          hit_one;
    logic                          hit_zero;
    logic                          take_bit;
    logic [irpd_pkg::CmdBits-1:0]  bit_mask;

    // Interval since the channel's previous edge, wrapping
    assign dt = timestamp - cur.last_time;

    // Exclusive windows
    assign hit_caption = (dt > irpd_pkg::TimeBits'(cfg.caption_min))
                      && (dt < irpd_pkg::TimeBits'(cfg.caption_max));
    assign hit_one     = (dt > irpd_pkg::TimeBits'(cfg.one_min))
                      && (dt < irpd_pkg::TimeBits'(cfg.one_max));
    assign hit_zero    = (dt > irpd_pkg::TimeBits'(cfg.zero_min))
                      && (dt < irpd_pkg::TimeBits'(cfg.zero_max));

    assign bit_mask = irpd_pkg::CmdBits'(1) << cur.bit_idx;
    assign take_bit = pin_high && !hit_caption && (hit_one || hit_zero) && !cur.done;

    // Compute next state, caption first, then one, then zero
    always_comb
    begin
        nxt           = cur;
        nxt.last_time = timestamp;
        fresh         = 1'b0;
        if (pin_high && hit_caption)
        begin
            nxt.shift_data = '0;
            nxt.done       = 1'b0;
            nxt.bit_idx    = irpd_pkg::BitIdxBits'(irpd_pkg::CmdBits - 1);
        end
        else if (take_bit)
        begin
            if (hit_one)
            begin
                nxt.shift_data = cur.shift_data | bit_mask;
            end
            if (cur.bit_idx == '0)
            begin
                nxt.done    = 1'b1;
                nxt.latched = nxt.shift_data;
                fresh       = 1'b1;
            end
            else
            begin
                nxt.bit_idx = cur.bit_idx - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/ir_pulse_width_decoder.sv */
`default_nettype none

// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// evt      in         evt_valid / evt_ready  evt (channel, pin_high, timestamp)
// res      out        res_valid / res_ready  res (out_channel, command, new_command)
//
// One pin request per cycle while evt_ready is high. A request reads its
// channel's state from one state RAM at acceptance, is updated and written
// back when the update stage advances, which also loads the output register.
// A write followed at once by a read of the same channel is bypassed.
// After reset every channel reads as its reset state through per-entry flags;
// there is no clearing pass. A stalled result holds the update stage, and
// evt_ready drops only while both stages are full and the output is stalled.

module ir_pulse_width_decoder #(
    parameter int CHANNELS = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [irpd_pkg::RegIdxBits-1:0]    cfg_index,
    input  wire logic [irpd_pkg::WinBits-1:0]       cfg_data,
    input  wire logic                               evt_valid,
    output logic                                    evt_ready,
    input  wire irpd_pkg::evt_t                     evt,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output irpd_pkg::res_t                          res
);

    localparam int AddrW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WideW  = (AddrW > irpd_pkg::ChanBits) ? AddrW : irpd_pkg::ChanBits;
    localparam int StateW = $bits(irpd_pkg::chan_state_t);

    irpd_pkg::win_cfg_t    cfg_reg;
    logic                  s1_valid_reg;
    irpd_pkg::evt_t        s1_evt_reg;
    logic                  res_valid_reg;
    irpd_pkg::res_t        res_reg;
    logic [CHANNELS-1:0]   entry_valid_reg;
    logic                  fwd_valid_reg;
    logic [AddrW-1:0]      fwd_addr_reg;
    irpd_pkg::chan_state_t fwd_data_reg;

    logic                  evt_take;
    logic                  s1_go;
    logic [WideW-1:0]      in_wide;
    logic [AddrW-1:0]      rd_addr;
    logic [WideW-1:0]      s1_wide;
    logic [AddrW-1:0]      s1_addr;
    logic                  s1_in_range;
    logic [StateW-1:0]     rd_data;
    irpd_pkg::chan_state_t cur_state;
    irpd_pkg::chan_state_t nxt_state;
    logic                  fresh;
    logic                  wr_en;
    irpd_pkg::res_t        res_next;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.caption_min <= irpd_pkg::CAPTION_MIN_RST;
            cfg_reg.caption_max <= irpd_pkg::CAPTION_MAX_RST;
            cfg_reg.one_min     <= irpd_pkg::ONE_MIN_RST;
            cfg_reg.one_max     <= irpd_pkg::ONE_MAX_RST;
            cfg_reg.zero_min    <= irpd_pkg::ZERO_MIN_RST;
            cfg_reg.zero_max    <= irpd_pkg::ZERO_MAX_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                irpd_pkg::REG_CAPTION_MIN: cfg_reg.caption_min <= cfg_data;
                irpd_pkg::REG_CAPTION_MAX: cfg_reg.caption_max <= cfg_data;
                irpd_pkg::REG_ONE_MIN:     cfg_reg.one_min     <= cfg_data;
                irpd_pkg::REG_ONE_MAX:     cfg_reg.one_max     <= cfg_data;
                irpd_pkg::REG_ZERO_MIN:    cfg_reg.zero_min    <= cfg_data;
                irpd_pkg::REG_ZERO_MAX:    cfg_reg.zero_max    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshakes
    assign s1_go     = s1_valid_reg && (!res_valid_reg || res_ready);
    assign evt_ready = !s1_valid_reg || s1_go;
    assign evt_take  = evt_valid && evt_ready;

    // Channel addresses
    assign in_wide     = WideW'(evt.channel);
    assign rd_addr     = in_wide[AddrW-1:0];
    assign s1_wide     = WideW'(s1_evt_reg.channel);
    assign s1_addr     = s1_wide[AddrW-1:0];
    assign s1_in_range = ({1'b0, s1_wide} < (WideW + 1)'(CHANNELS));

    irpd_ram #(
        .WIDTH (StateW),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (nxt_state),
        .rd_en   (evt_take),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Select current state: bypass, stored entry, or reset value
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
        begin
            cur_state = fwd_data_reg;
        end
        else if (entry_valid_reg[s1_addr])
        begin
            cur_state = irpd_pkg::chan_state_t'(rd_data);
        end
        else
        begin
            cur_state = irpd_pkg::STATE_RST;
        end
    end

    irpd_update u_update (
        .cfg       (cfg_reg),
        .cur       (cur_state),
        .pin_high  (s1_evt_reg.pin_high),
        .timestamp (s1_evt_reg.timestamp),
        .nxt       (nxt_state),
        .fresh     (fresh)
    );

    assign wr_en = s1_go && s1_in_range;

    // Build the result
    always_comb
    begin
        res_next.out_channel = s1_evt_reg.channel;
        res_next.command     = s1_in_range ? nxt_state.latched : '0;
        res_next.new_command = s1_in_range && fresh;
    end

    // Advance the update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (evt_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            s1_evt_reg <= evt;
        end
    end

    // Track written entries and hold the last write for bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            entry_valid_reg[s1_addr] <= 1'b1;
            fwd_valid_reg            <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= nxt_state;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* dv/ir_pulse_width_decoder_tb.sv */
`timescale 1ns / 1ps

module ir_pulse_width_decoder_tb;

    localparam int CHANNELS     = 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int LIMIT_NS     = 2_400_000;

    // Register indexes past the window registers; writes there must be dropped
    localparam logic [irpd_pkg::RegIdxBits-1:0] REG_SPARE_A = 3'd6;
    localparam logic [irpd_pkg::RegIdxBits-1:0] REG_SPARE_B = 3'd7;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE, RDY_PATTERN} ready_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [irpd_pkg::RegIdxBits-1:0] cfg_index = '0;
    logic [irpd_pkg::WinBits-1:0]    cfg_data = '0;
    logic                            evt_valid = 1'b0;
    logic                            evt_ready;
    irpd_pkg::evt_t                  evt = '0;
    logic                            res_valid;
    logic                            res_ready = 1'b0;
    irpd_pkg::res_t                  res;

    // Decoder copy: windows and per-channel state as the block should hold them
    irpd_pkg::win_cfg_t window_regs = '{
        caption_min: irpd_pkg::CAPTION_MIN_RST,
        caption_max: irpd_pkg::CAPTION_MAX_RST,
        one_min:     irpd_pkg::ONE_MIN_RST,
        one_max:     irpd_pkg::ONE_MAX_RST,
        zero_min:    irpd_pkg::ZERO_MIN_RST,
        zero_max:    irpd_pkg::ZERO_MAX_RST
    };
    logic [irpd_pkg::TimeBits-1:0] chan_last_time [CHANNELS] = '{default: '0};
    logic [irpd_pkg::CmdBits-1:0]  chan_shift     [CHANNELS] = '{default: '0};
    int                            chan_bit_pos   [CHANNELS] =
                                       '{default: irpd_pkg::CmdBits - 1};
    logic [irpd_pkg::CmdBits-1:0]  chan_command   [CHANNELS] = '{default: '0};

    irpd_pkg::res_t awaited_decodes [$];

    // Stimulus side bookkeeping
    logic [irpd_pkg::TimeBits-1:0] stim_time   [CHANNELS] = '{default: '0};
    int                            frame_pos   [CHANNELS] = '{default: 0};
    int                            frame_extra [CHANNELS] = '{default: 0};
    int                            burst_left = 0;
    bit                            sender_idles = 1'b0;
    ready_mode_t                   rdy_mode = RDY_ALWAYS;
    int                            hold_request = 0;
    int                            hold_left = 0;
    logic [6:0]                    stall_pattern = 7'b1011001;

    int mismatch_count  = 0;
    int events_sent     = 0;
    int words_completed = 0;
    int window_sets     = 0;

    ir_pulse_width_decoder #(
        .CHANNELS(CHANNELS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit window_hit(logic [irpd_pkg::TimeBits-1:0] interval,
                                      logic [irpd_pkg::WinBits-1:0] lo,
                                      logic [irpd_pkg::WinBits-1:0] hi);
        return interval > irpd_pkg::TimeBits'(lo) && interval < irpd_pkg::TimeBits'(hi);
    endfunction

    // Advance one channel on a pin request and return the result it should give
    function automatic irpd_pkg::res_t decode_pin_event(irpd_pkg::evt_t e);
        logic [irpd_pkg::TimeBits-1:0] interval;
        int                            ch;
        int                            prior;
        irpd_pkg::res_t                r;
        ch = int'(e.channel);
        r.out_channel = e.channel;
        r.new_command = 1'b0;
        if (e.pin_high)
        begin
            interval = e.timestamp - chan_last_time[ch];
            prior = chan_bit_pos[ch];
            if (window_hit(interval, window_regs.caption_min, window_regs.caption_max))
            begin
                chan_shift[ch] = '0;
                chan_bit_pos[ch] = irpd_pkg::CmdBits - 1;
            end
            else if (window_hit(interval, window_regs.one_min, window_regs.one_max))
            begin
                if (chan_bit_pos[ch] >= 0)
                begin
                    chan_shift[ch][chan_bit_pos[ch]] = 1'b1;
                    chan_bit_pos[ch]--;
                end
            end
            else if (window_hit(interval, window_regs.zero_min, window_regs.zero_max))
            begin
                if (chan_bit_pos[ch] >= 0)
                    chan_bit_pos[ch]--;
            end
            // latch the word on the request that takes the last bit
            if (prior >= 0 && chan_bit_pos[ch] < 0)
            begin
                chan_command[ch] = chan_shift[ch];
                r.new_command = 1'b1;
            end
        end
        chan_last_time[ch] = e.timestamp;
        r.command = chan_command[ch];
        return r;
    endfunction

    // Track config writes, predict on accepted requests, check each result
    always @(posedge clk)
    begin
        irpd_pkg::res_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    irpd_pkg::REG_CAPTION_MIN: window_regs.caption_min = cfg_data;
                    irpd_pkg::REG_CAPTION_MAX: window_regs.caption_max = cfg_data;
                    irpd_pkg::REG_ONE_MIN:     window_regs.one_min = cfg_data;
                    irpd_pkg::REG_ONE_MAX:     window_regs.one_max = cfg_data;
                    irpd_pkg::REG_ZERO_MIN:    window_regs.zero_min = cfg_data;
                    irpd_pkg::REG_ZERO_MAX:    window_regs.zero_max = cfg_data;
                    default: ;
                endcase
            end
            if (evt_valid && evt_ready)
                awaited_decodes.push_back(decode_pin_event(evt));
            if (res_valid && res_ready)
            begin
                if (awaited_decodes.size() == 0)
                begin
                    $error("result with no request pending: out_channel %0d command %06h",
                           res.out_channel, res.command);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_decodes.pop_front();
                    if (res.out_channel !== want.out_channel)
                    begin
                        $error("out_channel: expected %0d, got %0d",
                               want.out_channel, res.out_channel);
                        mismatch_count++;
                    end
                    if (res.command !== want.command)
                    begin
                        $error("command: expected %06h, got %06h", want.command, res.command);
                        mismatch_count++;
                    end
                    if (res.new_command !== want.new_command)
                    begin
                        $error("new_command: expected %0d, got %0d",
                               want.new_command, res.new_command);
                        mismatch_count++;
                    end
                    if (want.new_command)
                        words_completed++;
                end
            end
        end
    end

    // Drive result ready: a long hold when asked, otherwise the current stall mode
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
        begin
            case (rdy_mode)
                RDY_ALWAYS:  res_ready <= 1'b1;
                RDY_RANDOM:  res_ready <= ($urandom_range(0, 99) < 60);
                RDY_SPARSE:  res_ready <= ($urandom_range(0, 99) < 25);
                RDY_PATTERN:
                begin
                    res_ready <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[6:1]};
                end
                default:     res_ready <= 1'b1;
            endcase
        end
    end

    // Offer one pin request; entered and left at a falling edge, valid left high
    task automatic send_evt(int ch, logic high, logic [irpd_pkg::TimeBits-1:0] ts);
        irpd_pkg::evt_t e;
        int unsigned    gap;
        if (burst_left == 0)
        begin
            if (sender_idles)
            begin
                gap = $urandom_range(1, 6);
                evt_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        e.channel = irpd_pkg::ChanBits'(ch);
        e.pin_high = high;
        e.timestamp = ts;
        stim_time[ch] = ts;
        evt <= e;
        evt_valid <= 1'b1;
        @(posedge clk);
        while (!evt_ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        events_sent++;
    endtask

    task automatic send_after(int ch, logic high, logic [irpd_pkg::TimeBits-1:0] interval);
        send_evt(ch, high, stim_time[ch] + interval);
    endtask

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic wait_idle();
        evt_valid <= 1'b0;
        burst_left = 0;
        while (awaited_decodes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [irpd_pkg::RegIdxBits-1:0] idx,
                             logic [irpd_pkg::WinBits-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_windows(irpd_pkg::win_cfg_t w);
        write_reg(irpd_pkg::REG_CAPTION_MIN, w.caption_min);
        write_reg(irpd_pkg::REG_CAPTION_MAX, w.caption_max);
        write_reg(irpd_pkg::REG_ONE_MIN, w.one_min);
        write_reg(irpd_pkg::REG_ONE_MAX, w.one_max);
        write_reg(irpd_pkg::REG_ZERO_MIN, w.zero_min);
        write_reg(irpd_pkg::REG_ZERO_MAX, w.zero_max);
        cfg_valid <= 1'b0;
        window_sets++;
    endtask

    // Interval strictly inside a window, or a stray one if the window is empty
    function automatic logic [irpd_pkg::TimeBits-1:0] pick_in(
        logic [irpd_pkg::WinBits-1:0] lo,
        logic [irpd_pkg::WinBits-1:0] hi);
        if (int'(hi) > int'(lo) + 1)
            return $urandom_range(int'(lo) + 1, int'(hi) - 1);
        return $urandom_range(0, 300);
    endfunction

    // Interleaved frames on random channels: caption, 24 bits, up to three surplus bits.
    // noise_pct of the requests are random pin events that break the frames.
    task automatic run_frames(int count, int noise_pct);
        int                            ch;
        int                            stop_at;
        logic [irpd_pkg::TimeBits-1:0] interval;
        stop_at = events_sent + count;
        while (events_sent < stop_at)
        begin
            ch = $urandom_range(0, CHANNELS - 1);
            if ($urandom_range(0, 99) < noise_pct)
            begin
                if ($urandom_range(0, 1))
                    send_evt(ch, 1'($urandom_range(0, 1)), $urandom);
                else
                    send_after(ch, 1'($urandom_range(0, 1)), $urandom_range(0, 300));
            end
            else
            begin
                if (frame_pos[ch] == 0)
                    interval = pick_in(window_regs.caption_min, window_regs.caption_max);
                else
                begin
                    if ($urandom_range(0, 1))
                        interval = pick_in(window_regs.one_min, window_regs.one_max);
                    else
                        interval = pick_in(window_regs.zero_min, window_regs.zero_max);
                    // a falling edge in between moves the reference time
                    if ($urandom_range(0, 3) == 0)
                        send_after(ch, 1'b0, $urandom_range(1, 300));
                end
                send_after(ch, 1'b1, interval);
                frame_pos[ch]++;
                if (frame_pos[ch] > irpd_pkg::CmdBits + frame_extra[ch])
                begin
                    frame_pos[ch] = 0;
                    frame_extra[ch] = $urandom_range(0, 3);
                end
                // now and then abandon a frame and restart with a caption
                if ($urandom_range(0, 49) == 0)
                    frame_pos[ch] = 0;
            end
        end
    endtask

    // Window boundaries under reset windows, timer wrap, falling edges
    task automatic test_window_edges();
        sender_idles = 1'b1;
        rdy_mode = RDY_RANDOM;
        send_evt(7, 1'b1, '1);
        send_after(7, 1'b1, window_regs.caption_min + 1);
        send_after(7, 1'b0, window_regs.one_min + 2);
        send_after(7, 1'b1, window_regs.one_min + 1);
        send_after(7, 1'b1, window_regs.one_min);
        send_after(7, 1'b1, window_regs.one_max);
        send_after(7, 1'b1, window_regs.one_max - 1);
        send_after(7, 1'b1, window_regs.zero_min);
        send_after(7, 1'b1, window_regs.zero_min + 1);
        send_after(7, 1'b1, window_regs.zero_max - 1);
        send_after(7, 1'b1, window_regs.zero_max);
        send_after(7, 1'b1, window_regs.caption_min);
        send_after(7, 1'b1, window_regs.caption_max);
        send_after(7, 1'b1, window_regs.caption_max - 1);
        send_after(7, 1'b1, '0);
        send_evt(0, 1'b1, '0);
        send_evt(0, 1'b0, '1);
        send_after(0, 1'b1, window_regs.one_min + 1);
        send_evt(3, 1'b0, $urandom);
        send_evt(5, 1'b1, $urandom);
        wait_idle();
    endtask

    // Frames under the reset windows, first with gaps, then back to back
    task automatic test_default_frames();
        sender_idles = 1'b1;
        rdy_mode = RDY_RANDOM;
        run_frames(125, 4);
        sender_idles = 1'b0;
        rdy_mode = RDY_ALWAYS;
        run_frames(125, 4);
        wait_idle();
    endtask

    // Three random disjoint window layouts, each under its own flow pattern
    task automatic test_random_windows();
        irpd_pkg::win_cfg_t           w;
        int                           a, b, c, d, e, f;
        logic [irpd_pkg::WinBits-1:0] wa, wb, wc, wd, we, wf;
        for (int i = 0; i < 3; i++)
        begin
            a = $urandom_range(0, 60);
            b = a + 2 + $urandom_range(0, 20);
            c = b + $urandom_range(0, 10);
            d = c + 2 + $urandom_range(0, 20);
            e = d + $urandom_range(0, 10);
            f = e + 2 + $urandom_range(0, 40);
            wa = irpd_pkg::WinBits'(a);
            wb = irpd_pkg::WinBits'(b);
            wc = irpd_pkg::WinBits'(c);
            wd = irpd_pkg::WinBits'(d);
            we = irpd_pkg::WinBits'(e);
            wf = irpd_pkg::WinBits'(f);
            case ($urandom_range(0, 2))
                0: w = '{zero_min: wa, zero_max: wb, one_min: wc, one_max: wd,
                         caption_min: we, caption_max: wf};
                1: w = '{one_min: wa, one_max: wb, caption_min: wc, caption_max: wd,
                         zero_min: we, zero_max: wf};
                default: w = '{caption_min: wa, caption_max: wb, zero_min: wc, zero_max: wd,
                               one_min: we, one_max: wf};
            endcase
            load_windows(w);
            case (i)
                0:
                begin
                    sender_idles = 1'b0;
                    rdy_mode = RDY_ALWAYS;
                end
                1:
                begin
                    sender_idles = 1'b1;
                    rdy_mode = RDY_PATTERN;
                end
                default:
                begin
                    sender_idles = 1'b1;
                    rdy_mode = RDY_SPARSE;
                end
            endcase
            run_frames(80, 6);
            wait_idle();
        end
    endtask

    // Windows reaching 0 and 255, then overlapping windows to check priority
    task automatic test_wide_windows();
        sender_idles = 1'b1;
        rdy_mode = RDY_RANDOM;
        load_windows('{caption_min: 8'd200, caption_max: 8'd255,
                       one_min: 8'd100, one_max: 8'd200,
                       zero_min: 8'd0, zero_max: 8'd100});
        run_frames(150, 5);
        wait_idle();
        load_windows('{caption_min: 8'd20, caption_max: 8'd40,
                       one_min: 8'd30, one_max: 8'd60,
                       zero_min: 8'd0, zero_max: 8'd255});
        run_frames(80, 5);
        wait_idle();
    endtask

    // Inverted and empty windows never match; spare register writes do nothing
    task automatic test_dead_windows();
        write_reg(REG_SPARE_A, irpd_pkg::WinBits'($urandom));
        write_reg(REG_SPARE_B, irpd_pkg::WinBits'($urandom));
        load_windows('{caption_min: 8'd255, caption_max: 8'd0,
                       one_min: 8'd14, one_max: 8'd10,
                       zero_min: 8'd8, zero_max: 8'd8});
        sender_idles = 1'b0;
        rdy_mode = RDY_PATTERN;
        run_frames(40, 50);
        wait_idle();
    endtask

    // Hold the result side off while requests keep coming, so the input stalls
    task automatic test_output_stall();
        load_windows('{caption_min: irpd_pkg::CAPTION_MIN_RST,
                       caption_max: irpd_pkg::CAPTION_MAX_RST,
                       one_min: irpd_pkg::ONE_MIN_RST, one_max: irpd_pkg::ONE_MAX_RST,
                       zero_min: irpd_pkg::ZERO_MIN_RST, zero_max: irpd_pkg::ZERO_MAX_RST});
        sender_idles = 1'b0;
        rdy_mode = RDY_ALWAYS;
        @(posedge clk);
        hold_request = HOLD_CYCLES;
        @(negedge clk);
        run_frames(60, 5);
        wait_idle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_window_edges();
        test_default_frames();
        test_random_windows();
        test_wide_windows();
        test_dead_windows();
        test_output_stall();
        $display("Covered %0d pin requests on %0d channels over %0d window loads,",
                 events_sent, CHANNELS, window_sets);
        $display("with %0d command words completed and one %0d-cycle output hold-off.",
                 words_completed, HOLD_CYCLES);
        if (mismatch_count == 0 && awaited_decodes.size() == 0)
            $display("PASS ir_pulse_width_decoder");
        else
            $display("FAIL ir_pulse_width_decoder");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(LIMIT_NS);
        $display("FAIL ir_pulse_width_decoder");
        $finish;
    end

endmodule
